// File: sv/cbc_pkg.sv
// Shared types and constants for the CBC substitution cipher block.
package cbc_pkg;

    localparam logic [1:0] OP_LOAD_TAB = 2'd0;
    localparam logic [1:0] OP_LOAD_IV  = 2'd1;
    localparam logic [1:0] OP_DATA     = 2'd2;

    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_CIPHER_MODE = 1'b1;

    localparam logic MODE_ENCRYPT = 1'b0;

    typedef enum logic [1:0] {
        CL_TAB,
        CL_IV,
        CL_DATA
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] pos;
        logic [7:0] col;
        logic [7:0] val;
        logic       last;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic pop;
        logic busy;
        logic fill_ok;
    } t_bstat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_bstate;

endpackage

// File: sv/cbc_front.sv
// Input stage: classifies incoming items, drops ignored ones, and queues the rest.
module cbc_front import cbc_pkg::*; #(
    parameter int MAX_BLOCK = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_position,
    input  logic [7:0] i_column,
    input  logic [7:0] i_value,
    input  logic       i_last,
    input  logic       i_pop,
    output t_item      o_item,
    output t_qstat     o_qstat
);
    localparam int QD = 4;

    t_item      r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       keep, push;
    t_item      item;

    // Loads beyond the table rows and the unused operation code never enter the queue.
    always_comb begin
        item      = '{cls: CL_DATA, pos: i_position, col: i_column, val: i_value, last: i_last};
        keep      = 1'b0;
        case (i_operation)
            OP_LOAD_TAB: begin
                item.cls = CL_TAB;
                keep     = 32'(i_position) < MAX_BLOCK;
            end
            OP_LOAD_IV: begin
                item.cls = CL_IV;
                keep     = 32'(i_position) < MAX_BLOCK;
            end
            OP_DATA: begin
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_qstat.full  = (r_cnt == 3'(QD));
    assign o_qstat.empty = (r_cnt == 3'd0);
    assign o_stall       = o_qstat.full;
    assign push          = i_valid && !o_qstat.full && keep;
    assign o_item        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

endmodule

// File: sv/cbc_back.sv
// Cipher engine: owns the tables, IV, chain and block buffer, and emits blocks bytewise.
module cbc_back import cbc_pkg::*; #(
    parameter int MAX_BLOCK = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_item,
    input  logic [4:0] i_block_size,
    input  logic       i_cipher_mode,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_end,
    output t_bstat     o_bstat
);
    localparam int RW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int AW = RW + 8;
    localparam int MD = MAX_BLOCK * 256;

    logic [7:0] sub_mem [MD];
    logic [7:0] inv_mem [MD];
    logic [7:0] r_buf   [MAX_BLOCK];
    logic [7:0] r_iv    [MAX_BLOCK];
    logic [7:0] r_chain [MAX_BLOCK];

    t_bstate       r_state, n_state;
    logic [RW-1:0] r_j;
    logic [CW-1:0] r_n, r_fill, eff, fill_next;
    logic          r_short, r_last, r_from_iv;
    logic [7:0]    r_sub_q, r_inv_q;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_run_last, r_out_msg_end;

    logic          pop, rd_en, out_load, is_done, at_end;
    logic [7:0]    chain_b, buf_b, res, sub_byte;

    assign eff = (i_block_size == 5'd0) ? CW'(1) :
                 (32'(i_block_size) > MAX_BLOCK) ? CW'(MAX_BLOCK) : CW'(i_block_size);
    assign fill_next = (32'(r_fill) < MAX_BLOCK) ? r_fill + CW'(1) : r_fill;
    assign is_done   = (fill_next >= eff) || i_item.last;

    assign chain_b  = r_from_iv ? r_iv[r_j] : r_chain[r_j];
    assign buf_b    = r_buf[r_j];
    assign sub_byte = r_short ? chain_b : (buf_b ^ chain_b);
    assign at_end   = (CW'(r_j) + CW'(1)) == r_n;

    always_comb begin
        if (r_short)                          res = buf_b ^ r_sub_q;
        else if (i_cipher_mode == MODE_ENCRYPT) res = r_sub_q;
        else                                  res = r_inv_q ^ chain_b;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid && i_item.cls == CL_DATA && is_done) n_state = ST_READ;
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: if (out_load) n_state = at_end ? ST_IDLE : ST_READ;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        pop      = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: pop      = i_q_valid;
            ST_READ: rd_en    = 1'b1;
            ST_EMIT: out_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_from_iv   <= 1'b1;
            r_out_valid <= 1'b0;
            r_j         <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
            if (pop && i_item.cls == CL_DATA) begin
                r_j    <= '0;
                r_fill <= is_done ? r_fill : fill_next;
            end
            if (out_load) begin
                r_j <= r_j + RW'(1);
                if (at_end) begin
                    r_fill    <= '0;
                    r_from_iv <= r_last ? 1'b1 : (r_short ? r_from_iv : 1'b0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.cls == CL_DATA) begin
            if (32'(r_fill) < MAX_BLOCK) r_buf[r_fill[RW-1:0]] <= i_item.val;
            r_n     <= fill_next;
            r_short <= fill_next < eff;
            r_last  <= i_item.last;
        end
        if (pop && i_item.cls == CL_IV) r_iv[RW'(i_item.pos)] <= i_item.val;
        if (out_load) begin
            r_out_byte     <= res;
            r_out_run_last <= at_end;
            r_out_msg_end  <= r_last;
            if (!r_short) r_chain[r_j] <= (i_cipher_mode == MODE_ENCRYPT) ? res : buf_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.cls == CL_TAB) sub_mem[{RW'(i_item.pos), i_item.col}] <= i_item.val;
        if (rd_en) r_sub_q <= sub_mem[AW'({r_j, sub_byte})];
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.cls == CL_TAB) inv_mem[{RW'(i_item.pos), i_item.val}] <= i_item.col;
        if (rd_en) r_inv_q <= inv_mem[AW'({r_j, buf_b})];
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_run_last      = r_out_run_last;
    assign o_message_end   = r_out_msg_end;
    assign o_bstat.pop     = pop;
    assign o_bstat.busy    = (r_state != ST_IDLE);
    assign o_bstat.fill_ok = 32'(r_fill) <= MAX_BLOCK;

endmodule

// File: sv/cbc_block_substitution_cipher.sv
// Top level of the CBC-mode substitution block cipher with its register port.
//
// Items arrive on the input channel (i_valid / o_stall) and are accepted when
// i_valid is high and o_stall is low. Table loads write one substitution entry
// and its inverse, IV loads write one IV byte, and data bytes are buffered
// until a block is full or a byte marked last closes the message. A closed
// block then leaves on the output channel (o_valid / i_stall) one byte per
// transaction, with o_run_last on its final byte and o_message_end on every
// byte of the block that ends the message.
// A four-entry queue separates the input stage from the cipher engine, so
// loads and data bytes are taken at one per cycle while the queue has
// room. For each emitted byte the engine first performs a registered table
// read, then forms the result and loads it into the output register; the
// table memory port sets this order. A block starts leaving once the
// engine has dequeued its last byte.
// When the receiver stalls, the output register holds its transaction, the
// engine waits, and the queue fills until o_stall rises.
// Reset (i_rst_n low, synchronous) empties the queue, clears the block fill,
// restarts the chain from the IV and sets block_size to 16, encrypt mode.
// Tables and IV are undefined until loaded.
module cbc_block_substitution_cipher import cbc_pkg::*; #(
    parameter int MAX_BLOCK = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_position,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_message_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [4:0] r_block_size;
    logic       r_cipher_mode;
    t_item      q_item;
    t_qstat     qstat;
    t_bstat     bstat;
    logic       cfg_wr;

    // Registers sit at byte addresses 0 and 4; bit 2 of the address selects one.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= 5'd16;
            r_cipher_mode <= MODE_ENCRYPT;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BLOCK_SIZE) r_block_size  <= pwdata[4:0];
            else                            r_cipher_mode <= pwdata[0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_CIPHER_MODE) prdata = {31'd0, r_cipher_mode};
        else                             prdata = {27'd0, r_block_size};
    end

    cbc_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_column    (i_column),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_pop       (bstat.pop),
        .o_item      (q_item),
        .o_qstat     (qstat)
    );

    cbc_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (!qstat.empty),
        .i_item        (q_item),
        .i_block_size  (r_block_size),
        .i_cipher_mode (r_cipher_mode),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end),
        .o_bstat       (bstat)
    );

    // The engine takes nothing from the queue while it is emitting a block.
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(bstat.pop && bstat.busy))
        else $error("queue popped while engine busy");

    // The block fill never passes the buffer depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.fill_ok)
        else $error("block fill beyond buffer depth");

    // An empty queue is never popped.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule
